>>> sv/mrlb_pkg.sv
`default_nettype none
package mrlb_pkg;

   localparam int WordWidthBits = 16;
   localparam int GapWidthBits  = 16;
   localparam int LineEndBits   = 7;
   localparam int LenBits       = 24;
   localparam int CostBits      = 31;

   localparam logic [CostBits-1:0] COST_CAP  = 31'h7FFF_FFFF;
   // largest leftover whose square stays below the cost cap
   localparam logic [LenBits-1:0]  REST_MAX  = 24'd46340;

   localparam logic CSR_PAGE_WIDTH = 1'b0;
   localparam logic CSR_FIRST_IND  = 1'b1;

   typedef enum logic [11:0] {
      ST_LOAD   = 12'b0000_0000_0001,
      ST_INIT   = 12'b0000_0000_0010,
      ST_PSTART = 12'b0000_0000_0100,
      ST_READ   = 12'b0000_0000_1000,
      ST_ADD    = 12'b0000_0001_0000,
      ST_CHK    = 12'b0000_0010_0000,
      ST_MUL    = 12'b0000_0100_0000,
      ST_ACC    = 12'b0000_1000_0000,
      ST_FIN    = 12'b0001_0000_0000,
      ST_ERD    = 12'b0010_0000_0000,
      ST_CALC   = 12'b0100_0000_0000,
      ST_OUT    = 12'b1000_0000_0000
   } state_type;

endpackage
`default_nettype wire

>>> sv/min_raggedness_line_breaker.sv
// minimum-raggedness line breaker for one paragraph
//
// req channel: one transaction per word (width, gap before it, attached flag,
// last_word). words are taken one per cycle while the block is loading; a
// transaction with last_word set, or the one that fills the word store, ends
// the paragraph and starts the solve. req_stall stays high from then until the
// last line has been delivered.
// solve: a backward dynamic program over the positions, with adders, compares
// and one 16x16 squarer stepped by a small sequencer. each candidate line end
// steps through read, add and check, then square and accumulate when the line
// fits, the next word is not attached and it is not the paragraph's last line;
// each position adds a start and a finish step.
// rsp channel: one transaction per line, line_end is one past its last word,
// last_line marks the final one. each line steps through read, calc and output
// states; rsp payload is held in registers while rsp_stall is high.
// csr port: index 0 page_width, index 1 first_line_indent; write only when
// idle. reset (synchronous) restores 480 / 0 and empties the word count; the
// stores need no clearing, only entries of the current paragraph are read.
`default_nettype none
module min_raggedness_line_breaker
   import mrlb_pkg::*;
#(
   parameter int MAX_WORDS = 64
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_write,
   input  wire logic                     csr_index,
   input  wire logic [15:0]              csr_data,
   input  wire logic                     req_valid,
   output      logic                     req_stall,
   input  wire logic [WordWidthBits-1:0] req_word_width,
   input  wire logic signed [GapWidthBits-1:0] req_gap_width,
   input  wire logic                     req_attached,
   input  wire logic                     req_last_word,
   output      logic                     rsp_valid,
   input  wire logic                     rsp_stall,
   output      logic [LineEndBits-1:0]   rsp_line_end,
   output      logic                     rsp_last_line
);

   localparam int AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
   localparam int CW = $clog2(MAX_WORDS + 1);
   localparam logic [CW-1:0] N_MAX = CW'(MAX_WORDS);
   localparam logic [CW-1:0] ONE   = CW'(1);

   // word and solve stores
   logic [WordWidthBits-1:0] width_mem  [MAX_WORDS];
   logic [GapWidthBits-1:0]  gap_mem    [MAX_WORDS];
   logic                     attach_mem [MAX_WORDS];
   logic [CostBits-1:0]      cost_mem   [MAX_WORDS];
   logic [AW-1:0]            choice_mem [MAX_WORDS];

   logic [WordWidthBits-1:0] width_rd_ff;
   logic [GapWidthBits-1:0]  gap_rd_ff;
   logic                     attach_rd_ff;
   logic [CostBits-1:0]      cost_rd_ff;
   logic [AW-1:0]            choice_rd_ff;

   state_type state_ff, state_in;

   logic [15:0]          page_width_ff;
   logic [15:0]          first_indent_ff;
   logic [CW-1:0]        count_ff, count_in;
   logic [CW-1:0]        n_ff, n_in;
   logic [CW-1:0]        i_ff, i_in;
   logic [CW-1:0]        j_ff, j_in;
   logic [CW-1:0]        cur_ff, cur_in;
   logic signed [LenBits-1:0] len_ff, len_in;
   logic signed [LenBits-1:0] limit_ff, limit_in;
   logic signed [LenBits-1:0] rest_ff, rest_in;
   logic [31:0]          sq_ff, sq_in;
   logic                 sq_sat_ff, sq_sat_in;
   logic [CostBits-1:0]  best_ff, best_in;
   logic [CW-1:0]        pick_ff, pick_in;
   logic [CostBits-1:0]  last_cost_ff, last_cost_in;
   logic [CW-1:0]        line_end_ff, line_end_in;
   logic                 last_line_ff, last_line_in;

   logic                 req_take;
   logic                 mem_we;
   logic [AW-1:0]        wr_addr;
   logic [CostBits-1:0]  wr_cost;
   logic [AW-1:0]        wr_choice;
   logic [CW-1:0]        j_next;
   logic [32:0]          acc_sum;
   logic [CostBits-1:0]  acc_cost;
   logic [CW-1:0]        nx;

   assign req_stall     = (state_ff != ST_LOAD);
   assign req_take      = req_valid && !req_stall;
   assign rsp_valid     = (state_ff == ST_OUT);
   assign rsp_line_end  = LineEndBits'(line_end_ff);
   assign rsp_last_line = last_line_ff;
   assign j_next        = j_ff + ONE;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         page_width_ff   <= 16'd480;
         first_indent_ff <= 16'd0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_PAGE_WIDTH: page_width_ff   <= csr_data;
            CSR_FIRST_IND:  first_indent_ff <= csr_data;
            default:        page_width_ff   <= page_width_ff;
         endcase
      end
   end

   // word stores: written at load, read at j (width, gap) and j+1 (attach)
   always_ff @(posedge clock) begin
      if (req_take) begin
         width_mem[count_ff[AW-1:0]]  <= req_word_width;
         gap_mem[count_ff[AW-1:0]]    <= req_gap_width;
         attach_mem[count_ff[AW-1:0]] <= req_attached;
      end
      width_rd_ff  <= width_mem[j_ff[AW-1:0]];
      gap_rd_ff    <= gap_mem[j_ff[AW-1:0]];
      attach_rd_ff <= attach_mem[j_next[AW-1:0]];
   end

   // solve stores: written per position, cost read at j+1, choice at cur
   always_ff @(posedge clock) begin
      if (mem_we) begin
         cost_mem[wr_addr]   <= wr_cost;
         choice_mem[wr_addr] <= wr_choice;
      end
      cost_rd_ff   <= cost_mem[j_next[AW-1:0]];
      choice_rd_ff <= choice_mem[cur_ff[AW-1:0]];
   end

   // cost of the candidate line through j, saturating
   always_comb begin
      acc_sum = {1'b0, sq_ff} + {2'b00, cost_rd_ff};
      if (sq_sat_ff || acc_sum > {2'b00, COST_CAP}) begin
         acc_cost = COST_CAP;
      end else begin
         acc_cost = acc_sum[CostBits-1:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      n_in         = n_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      cur_in       = cur_ff;
      len_in       = len_ff;
      limit_in     = limit_ff;
      rest_in      = rest_ff;
      sq_in        = sq_ff;
      sq_sat_in    = sq_sat_ff;
      best_in      = best_ff;
      pick_in      = pick_ff;
      last_cost_in = last_cost_ff;
      line_end_in  = line_end_ff;
      last_line_in = last_line_ff;
      mem_we       = 1'b0;
      wr_addr      = i_ff[AW-1:0];
      wr_cost      = best_ff;
      wr_choice    = pick_ff[AW-1:0];
      nx           = ONE + CW'(choice_rd_ff);

      unique case (state_ff)
         ST_LOAD: begin
            if (req_take) begin
               n_in = count_ff + ONE;
               if (req_last_word || (count_ff + ONE) == N_MAX) begin
                  state_in = ST_INIT;
               end else begin
                  count_in = count_ff + ONE;
               end
            end
         end
         ST_INIT: begin
            // last position ends the paragraph at no cost
            mem_we       = 1'b1;
            wr_addr      = AW'(n_ff - ONE);
            wr_cost      = '0;
            wr_choice    = AW'(n_ff - ONE);
            last_cost_in = '0;
            if (n_ff == ONE) begin
               cur_in   = '0;
               state_in = ST_ERD;
            end else begin
               i_in     = n_ff - CW'(2);
               state_in = ST_PSTART;
            end
         end
         ST_PSTART: begin
            j_in    = i_ff;
            len_in  = '0;
            best_in = COST_CAP;
            pick_in = i_ff;
            if (i_ff == '0) begin
               limit_in = LenBits'($signed({1'b0, page_width_ff}))
                        - LenBits'($signed(first_indent_ff));
            end else begin
               limit_in = LenBits'($signed({1'b0, page_width_ff}));
            end
            state_in = ST_READ;
         end
         ST_READ: begin
            state_in = ST_ADD;
         end
         ST_ADD: begin
            if (j_ff != i_ff) begin
               len_in = len_ff + LenBits'($signed({1'b0, width_rd_ff}))
                      + LenBits'($signed(gap_rd_ff));
            end else begin
               len_in = len_ff + LenBits'($signed({1'b0, width_rd_ff}));
            end
            state_in = ST_CHK;
         end
         ST_CHK: begin
            if (len_ff > limit_ff) begin
               state_in = ST_FIN;
            end else if (j_next < n_ff && attach_rd_ff) begin
               // no break before an attached word
               if (j_next < n_ff) begin
                  j_in     = j_next;
                  state_in = ST_READ;
               end else begin
                  state_in = ST_FIN;
               end
            end else if (j_next == n_ff) begin
               // rest of the paragraph fits on the last line
               if (best_ff != '0) begin
                  best_in = '0;
                  pick_in = j_ff;
               end
               state_in = ST_FIN;
            end else begin
               rest_in  = limit_ff - len_ff;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            sq_sat_in = (rest_ff > REST_MAX);
            sq_in     = 32'(rest_ff[15:0]) * 32'(rest_ff[15:0]);
            state_in  = ST_ACC;
         end
         ST_ACC: begin
            if (acc_cost < best_ff) begin
               best_in = acc_cost;
               pick_in = j_ff;
            end
            if (j_next < n_ff) begin
               j_in     = j_next;
               state_in = ST_READ;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            mem_we = 1'b1;
            if (best_ff == COST_CAP) begin
               // nothing fits: one-word line, cost of the next position
               wr_cost      = last_cost_ff;
               wr_choice    = i_ff[AW-1:0];
               last_cost_in = last_cost_ff;
            end else begin
               last_cost_in = best_ff;
            end
            if (i_ff == '0) begin
               cur_in   = '0;
               state_in = ST_ERD;
            end else begin
               i_in     = i_ff - ONE;
               state_in = ST_PSTART;
            end
         end
         ST_ERD: begin
            state_in = ST_CALC;
         end
         ST_CALC: begin
            if (nx <= cur_ff) begin
               nx = cur_ff + ONE;
            end
            if (nx > n_ff) begin
               nx = n_ff;
            end
            line_end_in  = nx;
            last_line_in = (nx >= n_ff);
            cur_in       = nx;
            state_in     = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               if (last_line_ff) begin
                  count_in = '0;
                  state_in = ST_LOAD;
               end else begin
                  state_in = ST_ERD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      i_ff         <= i_in;
      j_ff         <= j_in;
      cur_ff       <= cur_in;
      len_ff       <= len_in;
      limit_ff     <= limit_in;
      rest_ff      <= rest_in;
      sq_ff        <= sq_in;
      sq_sat_ff    <= sq_sat_in;
      best_ff      <= best_in;
      pick_ff      <= pick_in;
      last_cost_ff <= last_cost_in;
      line_end_ff  <= line_end_in;
      last_line_ff <= last_line_in;
   end

endmodule
`default_nettype wire

>>> sv/mrlb_checker.sv
`default_nettype none
module mrlb_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_stall,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [6:0] rsp_line_end,
   input wire logic       rsp_last_line
);

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_line_end)
                                 && $stable(rsp_last_line))
      else $error("stalled rsp transaction changed");

   // words are never taken while lines are being delivered
   assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && !req_stall))
      else $error("req accepted during rsp");

   // no result right after reset
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("rsp valid after reset");

   // a line always ends past at least one word
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_line_end != 7'd0)
      else $error("empty line");

endmodule

bind min_raggedness_line_breaker mrlb_checker u_mrlb_checker (
   .clock         (clock),
   .reset         (reset),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_line_end  (rsp_line_end),
   .rsp_last_line (rsp_last_line)
);
`default_nettype wire
